/* rtl/evad_pkg.sv */
`timescale 1ns / 1ps

package evad_pkg;

  // Register map: register i sits at byte address 4*i.
  typedef enum logic [2:0] {
    REG_ON_MARGIN   = 3'd0,
    REG_MIN_LEVEL   = 3'd1,
    REG_ONSET_FRMS  = 3'd2,
    REG_MAX_SPEECH  = 3'd3,
    REG_UP_RATE     = 3'd4,
    REG_DOWN_RATE   = 3'd5
  } reg_idx_t;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned LEVEL_W  = 16;  // log10 level, Q3.12
  localparam int unsigned DB_W     = 21;  // 20 * level, Q.12 dB
  localparam int unsigned FLOOR_W  = 22;  // noise floor, Q.12 dB
  localparam int unsigned MARGIN_W = 19;
  localparam int unsigned MINLVL_W = 21;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned RATE_W   = 16;

  localparam logic signed [FLOOR_W:0] FLOOR_MAX = (FLOOR_W+1)'(2097151);
  localparam logic signed [FLOOR_W:0] FLOOR_MIN = -(FLOOR_W+1)'(2097152);

  typedef logic signed [DB_W-1:0]    db_t;
  typedef logic signed [FLOOR_W-1:0] floor_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [RATE_W-1:0]         rate_t;

endpackage

/* rtl/energy_vad_onset_detector_core.sv */
`timescale 1ns / 1ps

// An accepted input word passes through the input register, then the classify/track
// stage that loads the output register. Throughput: one word per cycle while the
// result side keeps up; the floor and run count update in a single pass.
// Reset (rst_n low, synchronous): registers return to their defaults, the tracker
// is cleared (floor zero, run count zero, not seeded) and both channels empty.
module energy_vad_onset_detector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] log_level (signed Q3.12)
  input  logic [0:0]                    in_tuser,   // [0] action (1 = restart)
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] onset, [1] speech, [7:2] zero
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [evad_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [evad_pkg::MARGIN_W-1:0]        on_margin_r;
  logic signed [evad_pkg::MINLVL_W-1:0] min_level_r;
  evad_pkg::count_t                     onset_frames_r;
  evad_pkg::count_t                     max_speech_r;
  evad_pkg::rate_t                      up_rate_r;
  evad_pkg::rate_t                      down_rate_r;

  logic               cfg_wr;
  evad_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // The low two address bits select a byte within the word and are ignored.
  assign cfg_idx    = evad_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_margin_r    <= evad_pkg::MARGIN_W'(40960);
      min_level_r    <= -evad_pkg::MINLVL_W'(204800);
      onset_frames_r <= evad_pkg::COUNT_W'(3);
      max_speech_r   <= evad_pkg::COUNT_W'(100);
      up_rate_r      <= evad_pkg::RATE_W'(655);
      down_rate_r    <= evad_pkg::RATE_W'(6554);
    end else if (cfg_wr) begin
      case (cfg_idx)
        evad_pkg::REG_ON_MARGIN:  on_margin_r    <= cfg_pwdata[evad_pkg::MARGIN_W-1:0];
        evad_pkg::REG_MIN_LEVEL:  min_level_r    <= cfg_pwdata[evad_pkg::MINLVL_W-1:0];
        evad_pkg::REG_ONSET_FRMS: onset_frames_r <= cfg_pwdata[evad_pkg::COUNT_W-1:0];
        evad_pkg::REG_MAX_SPEECH: max_speech_r   <= cfg_pwdata[evad_pkg::COUNT_W-1:0];
        evad_pkg::REG_UP_RATE:    up_rate_r      <= cfg_pwdata[evad_pkg::RATE_W-1:0];
        evad_pkg::REG_DOWN_RATE:  down_rate_r    <= cfg_pwdata[evad_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register value; the minimum level comes back sign-extended.
  always_comb begin
    case (cfg_idx)
      evad_pkg::REG_ON_MARGIN:  cfg_prdata = {13'd0, on_margin_r};
      evad_pkg::REG_MIN_LEVEL:  cfg_prdata = {{11{min_level_r[evad_pkg::MINLVL_W-1]}},
                                              min_level_r};
      evad_pkg::REG_ONSET_FRMS: cfg_prdata = {16'd0, onset_frames_r};
      evad_pkg::REG_MAX_SPEECH: cfg_prdata = {16'd0, max_speech_r};
      evad_pkg::REG_UP_RATE:    cfg_prdata = {16'd0, up_rate_r};
      evad_pkg::REG_DOWN_RATE:  cfg_prdata = {16'd0, down_rate_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register takes a new word whenever it is empty or its
  // word moves on this cycle; it moves on whenever the output register is empty
  // or its word is being taken. So a word enters every cycle while the result
  // side keeps up.
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic s1_fire;
  logic in_fire;

  assign advance   = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;
  assign s1_fire   = s1_valid_r & advance;

  // ---------------------------------------------------------------------------
  // Input register. The dB conversion (20 * level = 16x + 4x) is done on the
  // way in so the tracking stage starts from a ready dB value.
  // ---------------------------------------------------------------------------
  evad_pkg::db_t lvl_ext;
  evad_pkg::db_t db_in;
  evad_pkg::db_t s1_db_r;
  logic          s1_restart_r;

  assign lvl_ext = {{(evad_pkg::DB_W-evad_pkg::LEVEL_W){in_tdata[15]}}, in_tdata};
  assign db_in   = (lvl_ext <<< 4) + (lvl_ext <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_db_r      <= db_in;
      s1_restart_r <= in_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Classify and track. All comparisons are done at 24 bits signed, which
  // holds the floor plus the largest margin without overflow.
  // ---------------------------------------------------------------------------
  evad_pkg::floor_t floor_r;
  evad_pkg::count_t run_r;
  logic             seeded_r;

  evad_pkg::floor_t        floor_eff;
  logic signed [23:0]      db_w;
  logic signed [23:0]      floor_w;
  logic signed [23:0]      thresh_w;
  logic signed [23:0]      min_w;
  logic                    speech;
  logic                    run_sat;
  evad_pkg::count_t        run_inc;
  evad_pkg::count_t        run_upd;
  logic                    onset;
  logic                    track_en;
  evad_pkg::rate_t         rate_sel;
  logic signed [16:0]      rate_s;
  logic signed [22:0]      diff;
  logic signed [39:0]      prod;
  logic signed [23:0]      step;
  logic signed [24:0]      sum;
  evad_pkg::floor_t        tracked;
  evad_pkg::floor_t        floor_upd;

  // An unseeded tracker takes the current frame as its floor.
  assign floor_eff = seeded_r ? floor_r
                              : {{(evad_pkg::FLOOR_W-evad_pkg::DB_W){s1_db_r[evad_pkg::DB_W-1]}},
                                 s1_db_r};

  assign db_w     = {{(24-evad_pkg::DB_W){s1_db_r[evad_pkg::DB_W-1]}}, s1_db_r};
  assign floor_w  = {{(24-evad_pkg::FLOOR_W){floor_eff[evad_pkg::FLOOR_W-1]}}, floor_eff};
  assign thresh_w = floor_w + {{(24-evad_pkg::MARGIN_W){1'b0}}, on_margin_r};
  assign min_w    = {{(24-evad_pkg::MINLVL_W){min_level_r[evad_pkg::MINLVL_W-1]}},
                     min_level_r};

  assign speech = (db_w > thresh_w) && (db_w > min_w);

  // The run count saturates; onset fires only on an actual step to the target.
  assign run_sat = &run_r;
  assign run_inc = run_r + evad_pkg::COUNT_W'(1);
  assign run_upd = speech ? (run_sat ? run_r : run_inc) : '0;
  assign onset   = speech && !run_sat && (run_inc == onset_frames_r);

  // Outside speech the floor always tracks; within a long run it creeps up.
  assign track_en = !speech || (run_upd > max_speech_r);
  assign rate_sel = (!speech && (db_w < floor_w)) ? down_rate_r : up_rate_r;

  // floor += (rate * (db - floor)) >>> 16, then saturate to the floor width.
  assign rate_s = {1'b0, rate_sel};
  assign diff   = db_w[22:0] - floor_w[22:0];
  assign prod   = rate_s * diff;
  assign step   = prod[39:16];
  assign sum    = {floor_w[23], floor_w} + {step[23], step};

  always_comb begin
    if (sum > evad_pkg::FLOOR_MAX) begin
      tracked = evad_pkg::FLOOR_MAX[evad_pkg::FLOOR_W-1:0];
    end else if (sum < evad_pkg::FLOOR_MIN) begin
      tracked = evad_pkg::FLOOR_MIN[evad_pkg::FLOOR_W-1:0];
    end else begin
      tracked = sum[evad_pkg::FLOOR_W-1:0];
    end
  end

  assign floor_upd = track_en ? tracked : floor_eff;

  // Tracker state; a restart word clears it and reports neither speech nor onset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r  <= '0;
      run_r    <= '0;
      seeded_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_restart_r) begin
        floor_r  <= '0;
        run_r    <= '0;
        seeded_r <= 1'b0;
      end else begin
        floor_r  <= floor_upd;
        run_r    <= run_upd;
        seeded_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic onset_r;
  logic speech_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      onset_r  <= onset & ~s1_restart_r;
      speech_r <= speech & ~s1_restart_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, speech_r, onset_r};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the energy onset detector core.
//
// Input words carry one frame's log10 level on in_tdata and a restart flag on
// in_tuser. Every accepted input word is run through a bit-accurate software
// tracker inside this module, and the predicted onset/speech pair is queued.
// Each accepted result word is checked against the oldest queued pair.
//
// The run has four parts: a short directed sequence of corner cases, a check
// that a zero onset count never fires, six phases of random speech bursts
// under different register settings and stall patterns, and one long run of
// speech that fires late and lets the floor creep up during the run.
module testbench;
  import evad_pkg::*;

  // Restart flag values carried on in_tuser.
  localparam logic ACT_UPDATE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Saturation bounds of the 22-bit signed noise floor.
  localparam longint FLOOR_HI = 64'sd2097151;
  localparam longint FLOOR_LO = -64'sd2097152;

  // Cycles with no accepted word on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic onset;
    logic speech;
  } vad_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // [15:0] log_level
  logic [0:0]          in_tuser;   // [0] action
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [0] onset, [1] speech, [7:2] zero
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  energy_vad_onset_detector_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Software copy of the tuning registers.
  logic [MARGIN_W-1:0]        tune_margin;
  logic signed [MINLVL_W-1:0] tune_min_level;
  count_t                     tune_onset;
  count_t                     tune_max_run;
  rate_t                      tune_up;
  rate_t                      tune_down;

  // Software copy of the tracker state.
  floor_t trk_floor;
  count_t trk_run;
  logic   trk_seeded;

  // Predicted results, oldest first.
  vad_result_t pending_results[$];

  // Percentages of cycles in which each side holds off.
  int send_idle_pct;
  int recv_idle_pct;

  int frames_sent;
  int restarts_sent;
  int results_checked;
  int speech_seen;
  int onsets_seen;
  int mismatches;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tracker prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_tracker();
    trk_floor  = '0;
    trk_run    = '0;
    trk_seeded = 1'b0;
  endfunction

  function automatic longint clamp_floor(longint v);
    if (v > FLOOR_HI) return FLOOR_HI;
    if (v < FLOOR_LO) return FLOOR_LO;
    return v;
  endfunction

  // Move the floor a fraction of the way toward the frame level. The rate is
  // Q0.16 and the product is shifted arithmetically, so negative steps round
  // toward minus infinity.
  function automatic void nudge_floor(longint lvl_db, rate_t rate);
    longint step;
    step = (longint'(rate) * (lvl_db - longint'(trk_floor))) >>> 16;
    trk_floor = floor_t'(clamp_floor(longint'(trk_floor) + step));
  endfunction

  function automatic vad_result_t classify_frame(logic act, logic signed [LEVEL_W-1:0] lvl);
    vad_result_t res;
    longint      lvl_db;
    res = '0;
    if (act == ACT_RESTART) begin
      clear_tracker();
      return res;
    end
    // Level in dB is 20 times the log10 value, kept exactly in Q.12.
    lvl_db = 20 * longint'(lvl);
    if (!trk_seeded) begin
      trk_floor  = floor_t'(clamp_floor(lvl_db));
      trk_seeded = 1'b1;
    end
    res.speech = (lvl_db > longint'(trk_floor) + longint'(tune_margin)) &&
                 (lvl_db > longint'(tune_min_level));
    if (res.speech) begin
      // The run count sticks at its maximum, and a stuck count never fires again.
      if (trk_run != '1) begin
        trk_run   = trk_run + 1'b1;
        res.onset = (trk_run == tune_onset);
      end
      if (trk_run > tune_max_run) nudge_floor(lvl_db, tune_up);
    end else begin
      trk_run = '0;
      nudge_floor(lvl_db, (lvl_db < longint'(trk_floor)) ? tune_down : tune_up);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One APB write: a setup phase, then an access phase that completes on pready.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ON_MARGIN:  tune_margin    = val[MARGIN_W-1:0];
      REG_MIN_LEVEL:  tune_min_level = val[MINLVL_W-1:0];
      REG_ONSET_FRMS: tune_onset     = val[COUNT_W-1:0];
      REG_MAX_SPEECH: tune_max_run   = val[COUNT_W-1:0];
      REG_UP_RATE:    tune_up        = val[RATE_W-1:0];
      REG_DOWN_RATE:  tune_down      = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_tuning(int margin, int min_lvl, int onset, int max_run, int up, int down);
    write_reg(REG_ON_MARGIN,  32'(margin));
    write_reg(REG_MIN_LEVEL,  32'(min_lvl));
    write_reg(REG_ONSET_FRMS, 32'(onset));
    write_reg(REG_MAX_SPEECH, 32'(max_run));
    write_reg(REG_UP_RATE,    32'(up));
    write_reg(REG_DOWN_RATE,  32'(down));
  endtask

  // Offer one input word, with random hold-off first, and predict its result
  // once it is taken. in_tvalid stays high afterwards; the next call or the
  // drain decides what happens on the following falling edge.
  task automatic send_frame(logic act, logic signed [LEVEL_W-1:0] lvl);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= lvl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(classify_frame(act, lvl));
    frames_sent++;
    if (act == ACT_RESTART) restarts_sent++;
  endtask

  // Stop sending and wait for every predicted result, then wait on so the
  // pipeline is empty before registers change.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [LEVEL_W-1:0] clamp_level(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Random traffic shaped like speech: quiet stretches around a noise level,
  // then loud bursts that clear the current margin, so runs build up and fire.
  // A few restarts and raw random levels are mixed in.
  task automatic send_speech_bursts(int n_frames);
    int sent;
    int pick;
    int headroom;
    int span;
    int base;
    int quiet_len;
    int loud_len;
    sent = 0;
    headroom = int'(tune_margin) / 20 + 1;
    span = 65535 - headroom - 3000;
    if (span < 0) span = 0;
    while (sent < n_frames) begin
      pick = int'($urandom_range(99));
      if (pick < 4) begin
        send_frame(ACT_RESTART, 16'($urandom));
        sent++;
      end else if (pick < 14) begin
        send_frame(ACT_UPDATE, 16'($urandom));
        sent++;
      end else begin
        base      = -32768 + int'($urandom_range(span));
        quiet_len = int'($urandom_range(1, 6));
        loud_len  = int'($urandom_range(1, 12));
        repeat (quiet_len)
          send_frame(ACT_UPDATE, clamp_level(base + int'($urandom_range(400)) - 200));
        repeat (loud_len)
          send_frame(ACT_UPDATE, clamp_level(base + headroom + int'($urandom_range(3000))));
        sent += quiet_len + loud_len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and the watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) out_tready <= (int'($urandom_range(99)) >= recv_idle_pct);

  always @(posedge clk) begin : check_results
    vad_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tdata[0]) onsets_seen++;
      if (out_tdata[1]) speech_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result word %02h with nothing predicted", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.onset || out_tdata[1] !== want.speech ||
            out_tdata[7:2] !== 6'd0) begin
          if (mismatches < 10)
            $display("Result %0d mismatch: predicted onset=%0b speech=%0b, got word %02h",
                     results_checked, want.onset, want.speech, out_tdata);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  // Any accepted word on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("No word moved for %0d cycles, giving up", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases under the reset register values: seeding, an onset at the
  // third loud frame, both level extremes, restarts, the absolute minimum
  // level gate and a frame sitting exactly on the margin.
  task automatic test_directed_onset();
    send_frame(ACT_UPDATE, 16'sd0);
    repeat (4) send_frame(ACT_UPDATE, 16'sh7FFF);
    send_frame(ACT_UPDATE, 16'sh8000);
    send_frame(ACT_UPDATE, 16'sd1);
    send_frame(ACT_RESTART, 16'sh7FFF);
    send_frame(ACT_RESTART, 16'sh8000);
    // Seed at the bottom, then one frame on the minimum level and one just above.
    send_frame(ACT_UPDATE, 16'sh8000);
    send_frame(ACT_UPDATE, -16'sd10240);
    send_frame(ACT_UPDATE, -16'sd10239);
    // Seed at zero: 2048 lands exactly on the margin, 2100 clears it.
    send_frame(ACT_RESTART, 16'sd0);
    send_frame(ACT_UPDATE, 16'sd0);
    send_frame(ACT_UPDATE, 16'sd2048);
    send_frame(ACT_UPDATE, 16'sd2100);
  endtask

  // With an onset count of zero a run never fires. A run limit of one and
  // the fastest up rate also make the floor chase the level during speech.
  task automatic test_zero_onset();
    drain_results();
    set_tuning(0, 0, 0, 1, 65535, 6554);
    send_frame(ACT_RESTART, 16'sd0);
    send_frame(ACT_UPDATE, 16'sd0);
    repeat (5) send_frame(ACT_UPDATE, 16'sd20000);
    send_frame(ACT_UPDATE, 16'sd1);
  endtask

  // Six phases of bursts: reset values, all registers at low settings, all
  // at high settings, then three random settings. The stall pattern
  // changes every two phases, and each phase starts from an empty pipeline.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase / 2)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: set_tuning(40960, -204800, 3, 100, 655, 6554);
        1: set_tuning(0, -655360, 1, 1, 0, 0);
        2: set_tuning(327680, 0, 65534, 65534, 65535, 65535);
        default: set_tuning(int'($urandom_range(327680)), -int'($urandom_range(655360)),
                            int'($urandom_range(1, 6)), int'($urandom_range(1, 30)),
                            int'($urandom_range(65535)), int'($urandom_range(65535)));
      endcase
      send_speech_bursts(130);
    end
  endtask

  // One unbroken speech run from the bottom level to the top. The floor starts
  // creeping up after twenty frames, the onset fires once at the fortieth and
  // the rest of the run stays silent; a quiet frame then ends the run.
  task automatic test_long_run();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_tuning(0, -655360, 40, 20, 655, 6554);
    send_frame(ACT_RESTART, 16'sd0);
    send_frame(ACT_UPDATE, 16'sh8000);
    repeat (60) send_frame(ACT_UPDATE, 16'sh7FFF);
    send_frame(ACT_UPDATE, 16'sh8000);
    repeat (3) send_frame(ACT_UPDATE, 16'sh7FFF);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    frames_sent     = 0;
    restarts_sent   = 0;
    results_checked = 0;
    speech_seen     = 0;
    onsets_seen     = 0;
    mismatches      = 0;
    stall_cycles    = 0;
    send_idle_pct   = 12;
    recv_idle_pct   = 59;

    // Reset values of the registers and the tracker.
    tune_margin    = MARGIN_W'(40960);
    tune_min_level = MINLVL_W'(-204800);
    tune_onset     = 16'd3;
    tune_max_run   = 16'd100;
    tune_up        = 16'd655;
    tune_down      = 16'd6554;
    clear_tracker();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_onset();
    test_zero_onset();
    test_random_traffic();
    test_long_run();
    drain_results();

    $display("Sent %0d frames (%0d restarts); checked %0d results",
             frames_sent, restarts_sent, results_checked);
    $display("Results held %0d speech frames and %0d onsets", speech_seen, onsets_seen);
    $display("Covered corner levels, six register settings, three stall patterns, "
             , "a long speech run");
    if (pending_results.size() != 0)
      $display("%0d predicted results never arrived", pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
